[design/kct_pkg.sv]
// shared types and constants of the k-mer count table
`default_nettype none

package kct_pkg;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int SYM_W  = 2;
	localparam int IDX_W  = 12;
	localparam int VAL_W  = 32;
	localparam int ERR_W  = 2;
	localparam int ORD_W  = 3;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SYMBOL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_SATURATED = 2'd2;

	// register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_WORD_ORDER      = 2'd0;
	localparam logic [1:0] REG_COUNT_MODE      = 2'd1;
	localparam logic [1:0] REG_COMPLEMENT_MODE = 2'd2;

	// register reset values
	localparam logic [ORD_W-1:0] WORD_ORDER_RST = 3'd2;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [ORD_W-1:0] word_order;
		logic             count_mode;
		logic             complement_mode;
	} cfg_t;

	// control of one item from the window front end to the update stage
	typedef struct packed {
		logic             do_update;
		logic             do_read;
		logic             do_clear;
		logic             decrement;
		logic [IDX_W-1:0] word_index;
	} ctl_t;

	// one result item
	typedef struct packed {
		logic             counted;
		logic [IDX_W-1:0] word_index;
		logic [VAL_W-1:0] count_value;
		logic [ERR_W-1:0] error_code;
	} res_t;

endpackage

`default_nettype wire

[design/kct_if.sv]
// item channel interfaces for symbols in and results out
`default_nettype none

interface kct_in_if import kct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [SYM_W-1:0] symbol_code;
	logic             is_ambiguous;
	logic             last_of_sequence;
	logic [IDX_W-1:0] query_index;

	modport source (
		output valid, command, symbol_code, is_ambiguous, last_of_sequence, query_index,
		input  ready
	);
	modport sink (
		input  valid, command, symbol_code, is_ambiguous, last_of_sequence, query_index,
		output ready
	);
endinterface

interface kct_out_if import kct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             counted;
	logic [IDX_W-1:0] word_index;
	logic [VAL_W-1:0] count_value;
	logic [ERR_W-1:0] error_code;

	modport source (
		output valid, counted, word_index, count_value, error_code,
		input  ready
	);
	modport sink (
		input  valid, counted, word_index, count_value, error_code,
		output ready
	);
endinterface

`default_nettype wire

[design/kct_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module kct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[design/kct_cfg.sv]
// apb register block for word order, count mode and complement mode
`default_nettype none

module kct_cfg import kct_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,
	output      cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.word_order      <= WORD_ORDER_RST;
			cfg_q.count_mode      <= 1'b0;
			cfg_q.complement_mode <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_WORD_ORDER:      cfg_q.word_order      <= pwdata[ORD_W-1:0];
				REG_COUNT_MODE:      cfg_q.count_mode      <= pwdata[0];
				REG_COMPLEMENT_MODE: cfg_q.complement_mode <= pwdata[0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			REG_WORD_ORDER:      prdata = APB_DW'(cfg_q.word_order);
			REG_COUNT_MODE:      prdata = APB_DW'(cfg_q.count_mode);
			REG_COMPLEMENT_MODE: prdata = APB_DW'(cfg_q.complement_mode);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/kct_window.sv]
// sliding window front end: window index, ambiguity life, symbols seen, read issue
`default_nettype none

module kct_window import kct_pkg::*; #(
	parameter int MAX_ORDER  = 5,
	parameter int TABLE_BITS = 12,
	parameter int LEN_W      = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [SYM_W-1:0]      symbol_code,
	input  wire logic                  is_ambiguous,
	input  wire logic                  last_of_sequence,
	input  wire logic [IDX_W-1:0]      query_index,
	input  wire cfg_t                  cfg,
	output      logic                  rd_en,
	output      logic [TABLE_BITS-1:0] rd_addr,
	output      ctl_t                  ctl
);

	logic [TABLE_BITS-1:0]       window_q, window_d, wmask;
	logic [LEN_W-1:0]            life_q, life_d, seen_q, seen_d, wlen;
	logic [SYM_W-1:0]            code;
	logic [TABLE_BITS+IDX_W-1:0] win_ext, qry_ext, qm_ext;
	logic [TABLE_BITS-1:0]       qry_addr;
	logic                        word_ok;

	// word length, order clamped to the largest supported
	always_comb begin
		if (int'(cfg.word_order) > MAX_ORDER) begin
			wlen = LEN_W'(MAX_ORDER + 1);
		end else begin
			wlen = LEN_W'(int'(cfg.word_order) + 1);
		end
		for (int i = 0; i < TABLE_BITS; i++) begin
			wmask[i] = (i < SYM_W * int'(wlen));
		end
	end

	// next window state for a symbol
	always_comb begin
		code     = cfg.complement_mode ? ~symbol_code : symbol_code;
		window_d = window_q << SYM_W;
		if (is_ambiguous) begin
			life_d = wlen;
		end else begin
			life_d   = (life_q != '0) ? life_q - LEN_W'(1) : life_q;
			window_d = window_d | TABLE_BITS'(code);
		end
		window_d = window_d & wmask;
		seen_d   = (seen_q < wlen) ? seen_q + LEN_W'(1) : wlen;
		word_ok  = (life_d == '0) && (seen_d == wlen);
	end

	// index views: window to 12-bit field, query masked to the table
	always_comb begin
		win_ext  = {{IDX_W{1'b0}}, window_d};
		qry_ext  = {{TABLE_BITS{1'b0}}, query_index};
		qry_addr = qry_ext[TABLE_BITS-1:0];
		qm_ext   = {{IDX_W{1'b0}}, qry_addr};
	end

	// read issue and item control
	always_comb begin
		ctl           = '0;
		ctl.decrement = cfg.count_mode;
		rd_addr       = window_d;
		unique case (command)
			CMD_SYMBOL: begin
				ctl.do_update  = word_ok;
				ctl.word_index = win_ext[IDX_W-1:0];
			end
			CMD_READ: begin
				ctl.do_read    = 1'b1;
				ctl.word_index = qm_ext[IDX_W-1:0];
				rd_addr        = qry_addr;
			end
			CMD_CLEAR: begin
				ctl.do_clear = 1'b1;
			end
			default: begin
				ctl.decrement = 1'b0;
			end
		endcase
		rd_en = accept && (ctl.do_update || ctl.do_read);
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			life_q   <= '0;
			seen_q   <= '0;
		end else if (accept && command == CMD_SYMBOL) begin
			if (last_of_sequence) begin
				window_q <= '0;
				life_q   <= '0;
				seen_q   <= '0;
			end else begin
				window_q <= window_d;
				life_q   <= life_d;
				seen_q   <= seen_d;
			end
		end
	end

	// the end of a sequence restarts the window
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_SYMBOL && last_of_sequence
		|=> window_q == '0 && life_q == '0 && seen_q == '0)
		else $error("window not restarted after last symbol");

endmodule

`default_nettype wire

[design/kct_rmw.sv]
// read-modify-write stage with forwarding, and the table clearing sweep
`default_nettype none

module kct_rmw import kct_pkg::*; #(
	parameter int TABLE_BITS = 12,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire ctl_t                  ctl,
	input  wire logic [TABLE_BITS-1:0] rd_addr,
	input  wire logic [COUNT_BITS-1:0] rd_data,
	output      logic                  wr_en,
	output      logic [TABLE_BITS-1:0] wr_addr,
	output      logic [COUNT_BITS-1:0] wr_data,
	output      logic                  res_valid,
	output      res_t                  res,
	output      logic                  busy
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                        valid_s1;
	ctl_t                        ctl_s1;
	logic [TABLE_BITS-1:0]       addr_s1;
	logic                        fwd_valid_q;
	logic [TABLE_BITS-1:0]       fwd_addr_q;
	logic [COUNT_BITS-1:0]       fwd_data_q;
	logic                        clr_active_q;
	logic [TABLE_BITS-1:0]       clr_addr_q;
	logic [COUNT_BITS-1:0]       cur, upd;
	logic                        upd_en;
	logic [COUNT_BITS+VAL_W-1:0] val_ext;

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl;
			addr_s1 <= rd_addr;
		end
	end

	// forward the write that landed at the same edge as the read
	assign cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;

	// count update and result
	always_comb begin
		upd           = cur;
		upd_en        = 1'b0;
		val_ext       = '0;
		res           = '0;
		res.word_index = ctl_s1.word_index;
		if (ctl_s1.do_update) begin
			if (!ctl_s1.decrement) begin
				if (cur == COUNT_MAX) begin
					res.error_code = ERR_SATURATED;
					val_ext        = {{VAL_W{1'b0}}, COUNT_MAX};
				end else begin
					upd         = cur + COUNT_BITS'(1);
					upd_en      = 1'b1;
					res.counted = 1'b1;
					val_ext     = {{VAL_W{1'b0}}, upd};
				end
			end else begin
				if (cur == '0) begin
					res.error_code = ERR_UNDERFLOW;
				end else begin
					upd         = cur - COUNT_BITS'(1);
					upd_en      = 1'b1;
					res.counted = 1'b1;
					val_ext     = {{VAL_W{1'b0}}, upd};
				end
			end
		end else if (ctl_s1.do_read) begin
			val_ext = {{VAL_W{1'b0}}, cur};
		end else if (ctl_s1.do_clear) begin
			res.word_index = '0;
		end
		res.count_value = val_ext[VAL_W-1:0];
	end

	assign res_valid = valid_s1;

	// write port: sweep has priority, no item runs during it
	always_comb begin
		wr_en   = clr_active_q || (valid_s1 && upd_en);
		wr_addr = clr_active_q ? clr_addr_q : addr_s1;
		wr_data = clr_active_q ? '0 : upd;
	end

	// last write, for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= wr_addr;
		fwd_data_q <= wr_data;
	end

	// clearing sweep after reset and on a clear command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + TABLE_BITS'(1);
			if (clr_addr_q == {TABLE_BITS{1'b1}}) begin
				clr_active_q <= 1'b0;
			end
		end else if (valid_s1 && ctl_s1.do_clear) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end
	end

	assign busy = clr_active_q || (valid_s1 && ctl_s1.do_clear);

	// no item may be in flight while the sweep owns the memory
	a_sweep_alone: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1)
		else $error("item in flight during table sweep");

	// a clear item hands the memory to the sweep on the next cycle
	a_clear_starts: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.do_clear && !clr_active_q |=> clr_active_q && clr_addr_q == '0)
		else $error("clear command did not start the sweep");

endmodule

`default_nettype wire

[design/kct_outq.sv]
// two-entry result queue between the update stage and the result channel
`default_nettype none

module kct_outq import kct_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_res,
	input  wire logic pop,
	output      logic head_valid,
	output      res_t head,
	output      logic room
);

	res_t       slot0_q, slot1_q, slot0_d, slot1_d;
	logic [1:0] cnt_q, cnt_after, cnt_d;

	// next queue contents
	always_comb begin
		cnt_after = cnt_q - 2'(pop);
		slot0_d   = pop ? slot1_q : slot0_q;
		slot1_d   = slot1_q;
		if (push) begin
			if (cnt_after == 2'd0) begin
				slot0_d = push_res;
			end else begin
				slot1_d = push_res;
			end
		end
		cnt_d = cnt_after + 2'(push);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot0_q;

	// a new item may enter when its result will find a free slot
	assign room = (3'(cnt_q) + 3'(push)) <= (3'd1 + 3'(pop));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_q == 2'd2 && push && !pop))
		else $error("result queue overflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

endmodule

`default_nettype wire

[design/kmer_count_table.sv]
// top level of the k-mer count table: apb registers, window, count memory, update, results
// order: an accepted item is registered into stage 1 and its result then into the
// result queue that feeds results; a same-entry write landing with the read is forwarded.
// throughput: one item per cycle while the queue has room and no clearing pass runs;
// at most one read and one write of the count memory per item.
// reset: a clearing pass writes zero to all 2**(2*(MAX_ORDER+1)) entries (4096 by
// default) with symbols.ready low; a clear command runs the same pass after its result.
`default_nettype none

module kmer_count_table import kct_pkg::*; #(
	parameter int MAX_ORDER  = 5,
	parameter int COUNT_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	kct_in_if.sink                 symbols,
	kct_out_if.source              results,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready
);

	localparam int TABLE_BITS = SYM_W * (MAX_ORDER + 1);
	localparam int DEPTH      = 1 << TABLE_BITS;
	localparam int LEN_W      = $clog2(MAX_ORDER + 2);

	cfg_t                  cfg;
	ctl_t                  ctl;
	res_t                  res, head;
	logic                  accept, rd_en, wr_en, res_valid, busy, room, head_valid, pop;
	logic [TABLE_BITS-1:0] rd_addr, wr_addr;
	logic [COUNT_BITS-1:0] rd_data, wr_data;

	// handshakes
	assign symbols.ready = room && !busy;
	assign accept        = symbols.valid && symbols.ready;
	assign pop           = results.valid && results.ready;

	kct_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kct_window #(
		.MAX_ORDER  (MAX_ORDER),
		.TABLE_BITS (TABLE_BITS),
		.LEN_W      (LEN_W)
	) u_window (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.command          (symbols.command),
		.symbol_code      (symbols.symbol_code),
		.is_ambiguous     (symbols.is_ambiguous),
		.last_of_sequence (symbols.last_of_sequence),
		.query_index      (symbols.query_index),
		.cfg              (cfg),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.ctl              (ctl)
	);

	kct_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kct_rmw #(
		.TABLE_BITS (TABLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

	kct_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_res   (res),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.room       (room)
	);

	// result channel
	assign results.valid       = head_valid;
	assign results.counted     = head.counted;
	assign results.word_index  = head.word_index;
	assign results.count_value = head.count_value;
	assign results.error_code  = head.error_code;

endmodule

`default_nettype wire
